### hw/rtl/fdne_pkg.sv
package fdne_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 8;
  localparam int POS_W      = COORD_BITS + FRAC_BITS;
  localparam int OUT_W      = 12;
  localparam int RING_MAX   = 8;
  localparam int RING_IDX_W = $clog2(RING_MAX);
  localparam int RING_LEN_W = RING_IDX_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COORD_BITS-1:0] GRID_RESET = COORD_BITS'(255);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(1);

  localparam logic signed [1:0] OFF_M1 = 2'b11;
  localparam logic signed [1:0] OFF_Z  = 2'b00;
  localparam logic signed [1:0] OFF_P1 = 2'b01;

  localparam logic [RING_LEN_W-1:0] LEN_EDGE = RING_LEN_W'(6);
  localparam logic [RING_LEN_W-1:0] LEN_NODE = RING_LEN_W'(8);

  typedef enum logic [1:0] {
    KIND_HEDGE,
    KIND_VEDGE,
    KIND_NODE
  } kind_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] from_x;
    logic signed [OUT_W-1:0] from_y;
    logic signed [OUT_W-1:0] to_x;
    logic signed [OUT_W-1:0] to_y;
    logic                    edge_present;
    logic                    last_edge;
  } result_t;

  // One classified position waiting for the edge walker
  typedef struct packed {
    kind_t                  kind;
    logic [COORD_BITS-1:0]  ix;
    logic [COORD_BITS-1:0]  iy;
    logic [RING_MAX-1:0]    edges;
  } job_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } offset_t;

  function automatic logic [RING_LEN_W-1:0] ring_len(input kind_t k);
    logic [RING_LEN_W-1:0] len;
    case (k)
      KIND_NODE: len = LEN_NODE;
      default:   len = LEN_EDGE;
    endcase
    return len;
  endfunction

  function automatic logic [RING_IDX_W-1:0] ring_next(input kind_t k,
                                                     input logic [RING_IDX_W-1:0] i);
    logic [RING_LEN_W-1:0] nxt;
    nxt = {1'b0, i} + RING_LEN_W'(1);
    if (nxt == ring_len(k)) begin
      nxt = '0;
    end
    return nxt[RING_IDX_W-1:0];
  endfunction

  function automatic offset_t ring_off(input kind_t k, input logic [RING_IDX_W-1:0] i);
    offset_t o;
    o = '{dx: OFF_Z, dy: OFF_Z};
    case (k)
      KIND_HEDGE: begin
        case (i)
          3'd0:    o = '{dx: OFF_Z,  dy: OFF_Z};
          3'd1:    o = '{dx: OFF_Z,  dy: OFF_M1};
          3'd2:    o = '{dx: OFF_P1, dy: OFF_M1};
          3'd3:    o = '{dx: OFF_P1, dy: OFF_Z};
          3'd4:    o = '{dx: OFF_P1, dy: OFF_P1};
          3'd5:    o = '{dx: OFF_Z,  dy: OFF_P1};
          default: o = '{dx: OFF_Z,  dy: OFF_Z};
        endcase
      end
      KIND_VEDGE: begin
        case (i)
          3'd0:    o = '{dx: OFF_Z,  dy: OFF_Z};
          3'd1:    o = '{dx: OFF_P1, dy: OFF_Z};
          3'd2:    o = '{dx: OFF_P1, dy: OFF_P1};
          3'd3:    o = '{dx: OFF_Z,  dy: OFF_P1};
          3'd4:    o = '{dx: OFF_M1, dy: OFF_P1};
          3'd5:    o = '{dx: OFF_M1, dy: OFF_Z};
          default: o = '{dx: OFF_Z,  dy: OFF_Z};
        endcase
      end
      KIND_NODE: begin
        case (i)
          3'd0:    o = '{dx: OFF_P1, dy: OFF_Z};
          3'd1:    o = '{dx: OFF_P1, dy: OFF_P1};
          3'd2:    o = '{dx: OFF_Z,  dy: OFF_P1};
          3'd3:    o = '{dx: OFF_M1, dy: OFF_P1};
          3'd4:    o = '{dx: OFF_M1, dy: OFF_Z};
          3'd5:    o = '{dx: OFF_M1, dy: OFF_M1};
          3'd6:    o = '{dx: OFF_Z,  dy: OFF_M1};
          3'd7:    o = '{dx: OFF_P1, dy: OFF_M1};
          default: o = '{dx: OFF_Z,  dy: OFF_Z};
        endcase
      end
      default: o = '{dx: OFF_Z, dy: OFF_Z};
    endcase
    return o;
  endfunction

endpackage

### hw/rtl/field_dstar_neighbor_edges.sv
// An item's first result passes the queue, the walker's current-item register and the result
// register. The edge walker sends one result per cycle while it holds an item; each item gives
// one result per edge, or an empty marker if it has none (1 to 8 results).
// Items queue up (QUEUE_DEPTH deep) while the walker works; busy rises when the queue fills.
// Reset (rst, synchronous) empties the queue and sets both grid limits to 255.
// Results cannot be stalled and are taken in their strobe cycle.
module field_dstar_neighbor_edges #(
  parameter int QUEUE_DEPTH = fdne_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  fdne_pkg::point_t                    point,
  output logic                                result_valid,
  output fdne_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdne_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdne_pkg::COORD_BITS-1:0]     cfg_data
);

  logic [fdne_pkg::COORD_BITS-1:0] grid_length;
  logic [fdne_pkg::COORD_BITS-1:0] grid_width;
  fdne_pkg::job_t                  front_job;
  fdne_pkg::job_t                  q_job;
  logic                            q_full;
  logic                            q_empty;
  logic                            q_pop;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_length <= fdne_pkg::GRID_RESET;
      grid_width  <= fdne_pkg::GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdne_pkg::REG_GRID_LENGTH: grid_length <= cfg_data;
        fdne_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  fdne_front u_front (
    .point       (point),
    .grid_length (grid_length),
    .grid_width  (grid_width),
    .job         (front_job)
  );

  fdne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !busy),
    .push_data (front_job),
    .pop       (q_pop),
    .pop_data  (q_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  fdne_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (!q_empty),
    .job          (q_job),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !q_empty)
    else $error("accepted item did not reach the queue");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.edge_present |-> result.last_edge)
    else $error("empty marker without last flag");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.edge_present |->
      result.from_x == '0 && result.from_y == '0 && result.to_x == '0 && result.to_y == '0)
    else $error("empty marker carries coordinates");

  a_item_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_edge |=> result_valid && result.edge_present)
    else $error("edge run broken before its last edge");
`endif

endmodule

### hw/rtl/fdne_front.sv
module fdne_front (
  input  fdne_pkg::point_t                  point,
  input  logic [fdne_pkg::COORD_BITS-1:0]   grid_length,
  input  logic [fdne_pkg::COORD_BITS-1:0]   grid_width,
  output fdne_pkg::job_t                    job
);

  localparam int CB = fdne_pkg::COORD_BITS;

  logic [CB-1:0]                 ix;
  logic [CB-1:0]                 iy;
  logic                          frac_x;
  logic                          frac_y;
  fdne_pkg::kind_t               kind;
  logic [2:0]                    xok;
  logic [2:0]                    yok;
  logic [fdne_pkg::RING_MAX-1:0] node_ok;
  logic [fdne_pkg::RING_MAX-1:0] edges;

  function automatic logic pick(input logic [2:0] ok3, input logic signed [1:0] off);
    logic r;
    case (off)
      fdne_pkg::OFF_M1: r = ok3[0];
      fdne_pkg::OFF_Z:  r = ok3[1];
      fdne_pkg::OFF_P1: r = ok3[2];
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  assign ix     = point.pos_x[fdne_pkg::FRAC_BITS +: CB];
  assign iy     = point.pos_y[fdne_pkg::FRAC_BITS +: CB];
  assign frac_x = |point.pos_x[fdne_pkg::FRAC_BITS-1:0];
  assign frac_y = |point.pos_y[fdne_pkg::FRAC_BITS-1:0];

  always_comb begin
    if (frac_x) begin
      kind = fdne_pkg::KIND_HEDGE;
    end else if (frac_y) begin
      kind = fdne_pkg::KIND_VEDGE;
    end else begin
      kind = fdne_pkg::KIND_NODE;
    end
  end

  // Validity of coordinate-1, coordinate, coordinate+1 along each axis
  always_comb begin
    xok[0] = (ix != '0) && ({1'b0, ix} <= {1'b0, grid_length} + (CB+1)'(1));
    xok[1] = ix <= grid_length;
    xok[2] = ix < grid_length;
    yok[0] = (iy != '0) && ({1'b0, iy} <= {1'b0, grid_width} + (CB+1)'(1));
    yok[1] = iy <= grid_width;
    yok[2] = iy < grid_width;
  end

  always_comb begin
    fdne_pkg::offset_t off;
    logic [fdne_pkg::RING_IDX_W-1:0] idx;
    for (int i = 0; i < fdne_pkg::RING_MAX; i++) begin
      off = fdne_pkg::ring_off(kind, fdne_pkg::RING_IDX_W'(i));
      node_ok[i] = pick(xok, off.dx) & pick(yok, off.dy);
    end
    for (int i = 0; i < fdne_pkg::RING_MAX; i++) begin
      idx = fdne_pkg::RING_IDX_W'(i);
      edges[i] = ({1'b0, idx} < fdne_pkg::ring_len(kind)) && node_ok[i] &&
                 node_ok[fdne_pkg::ring_next(kind, idx)];
    end
  end

  always_comb begin
    job.kind  = kind;
    job.ix    = ix;
    job.iy    = iy;
    job.edges = edges;
  end

endmodule

### hw/rtl/fdne_queue.sv
module fdne_queue #(
  parameter int DEPTH = fdne_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fdne_pkg::job_t push_data,
  input  logic           pop,
  output fdne_pkg::job_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  fdne_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/fdne_back.sv
module fdne_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_avail,
  input  fdne_pkg::job_t    job,
  output logic              pop,
  output logic              result_valid,
  output fdne_pkg::result_t result
);

  localparam int OW = fdne_pkg::OUT_W;
  localparam int RI = fdne_pkg::RING_IDX_W;

  logic                          cur_valid;
  fdne_pkg::job_t                cur;
  logic [fdne_pkg::RING_MAX-1:0] rem;
  logic [fdne_pkg::RING_MAX-1:0] rem_next;
  logic [RI-1:0]                 idx;
  logic [RI-1:0]                 nidx;
  logic                          finish;
  fdne_pkg::result_t             res_next;
  fdne_pkg::offset_t             off_a;
  fdne_pkg::offset_t             off_b;

  function automatic logic [OW-1:0] coord(input logic [fdne_pkg::COORD_BITS-1:0] base,
                                          input logic signed [1:0] off);
    return OW'(base) + {{(OW-2){off[1]}}, off};
  endfunction

  // Lowest remaining edge goes out first, which keeps ring order
  always_comb begin
    idx = '0;
    for (int i = fdne_pkg::RING_MAX - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = RI'(i);
      end
    end
  end

  always_comb begin
    nidx     = fdne_pkg::ring_next(cur.kind, idx);
    off_a    = fdne_pkg::ring_off(cur.kind, idx);
    off_b    = fdne_pkg::ring_off(cur.kind, nidx);
    rem_next = rem & ~(fdne_pkg::RING_MAX'(1) << idx);
    if (rem == '0) begin
      res_next = '0;
      res_next.last_edge = 1'b1;
    end else begin
      res_next.from_x       = coord(cur.ix, off_a.dx);
      res_next.from_y       = coord(cur.iy, off_a.dy);
      res_next.to_x         = coord(cur.ix, off_b.dx);
      res_next.to_y         = coord(cur.iy, off_b.dy);
      res_next.edge_present = 1'b1;
      res_next.last_edge    = rem_next == '0;
    end
    finish = cur_valid && res_next.last_edge;
    pop    = job_avail && (!cur_valid || finish);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
      rem <= job.edges;
    end else if (cur_valid) begin
      rem <= rem_next;
    end
    result <= res_next;
  end

endmodule
